// ===== rtl/core/kcmb_pkg.sv =====
// ----------------------------------------------------------------------------
// kcmb_pkg
// Shared types, codes and reset values of the key chord to mouse button block
// ----------------------------------------------------------------------------
package kcmb_pkg;

	// sizing defaults
	localparam int BUFFER_DEPTH_DEF = 16;
	localparam int MAX_MAPS_DEF     = 6;
	localparam int NUM_ENTRY_REGS   = 6;

	// register indexes
	localparam logic [2:0] REG_NUM_BUTTONS = 3'd0;
	localparam logic [2:0] REG_MAP_FIRST   = 3'd1;
	localparam logic [2:0] REG_MAP_LAST    = 3'd6;

	// event types and sync codes
	localparam logic [1:0]  TYPE_KEY     = 2'd0;
	localparam logic [1:0]  TYPE_SYNC    = 2'd1;
	localparam logic [15:0] SYNC_REPORT  = 16'd0;
	localparam logic [15:0] SYNC_DROPPED = 16'd3;
	localparam logic [1:0]  VAL_RELEASE  = 2'd0;
	localparam logic [1:0]  VAL_REPEAT   = 2'd2;

	// pending change flag
	localparam logic [1:0] FLAG_NONE    = 2'd0;
	localparam logic [1:0] FLAG_CHANGED = 2'd1;
	localparam logic [1:0] FLAG_RESYNC  = 2'd2;

	// mapping entry: mouse code, main key, modifier (zero for none)
	typedef struct packed {
		logic [15:0] mouse;
		logic [15:0] key;
		logic [15:0] modifier;
	} entry_t;

	localparam logic [2:0] NUM_BUTTONS_RST = 3'd4;
	localparam logic [47:0] MAP_RST [NUM_ENTRY_REGS] = '{
		48'd1168239296512, 48'd1176829231160, 48'd1172532428800,
		48'd1176827396196, 48'd0, 48'd0
	};

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic key_upd;
		logic sync_upd;
		logic wr;
		logic rd;
		logic emit_buf;
		logic emit_btn;
		logic emit_sync;
		logic last;
		logic idx_inc;
		logic cnt_clr;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic typ_key;
		logic typ_sync;
		logic drop;
		logic full;
		logic cnt_zero;
		logic flush_done;
		logic btn_none;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/key_chord_to_mouse_button.sv =====
// ----------------------------------------------------------------------------
// key_chord_to_mouse_button
// Turns key chords into mouse button events on a keyboard event stream
// ----------------------------------------------------------------------------
// channel   | direction | handshake             | payload
// s_axis    | in        | tvalid/tready         | event_type, event_code, event_value
// m_axis    | out       | tvalid/tready, tlast  | out_type, out_code, out_value
// apb       | in        | psel/penable, pready  | 64-bit registers at 8*index
//
// a key event, unless it is a dropped repeat, is written to the buffer; a full buffer is flushed first
// a sync event flushes the held events, then emits changed buttons and the sync event;
// the event buffer has one registered read port, so each entry is read, then emitted
// reset clears key and button state and the fill count; no clearing pass
// a stalled output holds the sequencer; input is taken again once it is idle
// ----------------------------------------------------------------------------
module key_chord_to_mouse_button
	import kcmb_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int MAX_MAPS     = MAX_MAPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // event_type, event_code, event_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_type, out_code, out_value
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [2:0]                      num_buttons_q;
	entry_t [NUM_ENTRY_REGS-1:0]     map_q;
	logic [2:0]                      reg_idx;
	cmd_t                            cmd;
	sts_t                            sts;
	logic                            out_type;
	logic [15:0]                     out_code;
	logic [1:0]                      out_value;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_buttons_q <= NUM_BUTTONS_RST;
			for (int i = 0; i < NUM_ENTRY_REGS; i++) begin
				map_q[i] <= MAP_RST[i];
			end
		end else if (psel && penable && pwrite && pready) begin
			if (reg_idx == REG_NUM_BUTTONS) begin
				num_buttons_q <= pwdata[2:0];
			end else if ((reg_idx >= REG_MAP_FIRST) && (reg_idx <= REG_MAP_LAST)) begin
				map_q[reg_idx - REG_MAP_FIRST] <= pwdata[47:0];
			end
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_NUM_BUTTONS) begin
			prdata = {61'd0, num_buttons_q};
		end else if ((reg_idx >= REG_MAP_FIRST) && (reg_idx <= REG_MAP_LAST)) begin
			prdata = {16'd0, map_q[reg_idx - REG_MAP_FIRST]};
		end
	end

	kcmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kcmb_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.MAX_MAPS     (MAX_MAPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.num_buttons (num_buttons_q),
		.map_entry   (map_q[MAX_MAPS-1:0]),
		.in_type     (s_axis_tdata[1:0]),
		.in_code     (s_axis_tdata[17:2]),
		.in_value    (s_axis_tdata[19:18]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_type    (out_type),
		.out_code    (out_code),
		.out_value   (out_value),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, out_value, out_code, out_type};

endmodule

// ===== rtl/core/kcmb_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcmb_ctrl
// Sequencer: decodes an item, runs buffer write, buffer flush, button and sync emission
// ----------------------------------------------------------------------------
module kcmb_ctrl
	import kcmb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_FRD  = 3'd3;
	localparam logic [2:0] S_FEM  = 3'd4;
	localparam logic [2:0] S_BTN  = 3'd5;
	localparam logic [2:0] S_SYN  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       key_mode_q, key_mode_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			key_mode_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			key_mode_q <= key_mode_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d    = state_q;
		key_mode_d = key_mode_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.typ_key) begin
					if (sts.drop) begin
						state_d = S_IDLE;
					end else begin
						cmd.key_upd = 1'b1;
						key_mode_d  = 1'b1;
						state_d     = sts.full ? S_FRD : S_WR;
					end
				end else if (sts.typ_sync) begin
					cmd.sync_upd = 1'b1;
					key_mode_d   = 1'b0;
					state_d      = sts.cnt_zero ? S_BTN : S_FRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_WR: begin
				cmd.wr  = 1'b1;
				state_d = S_IDLE;
			end
			S_FRD: begin
				cmd.rd  = 1'b1;
				state_d = S_FEM;
			end
			S_FEM: begin
				if (sts.out_free) begin
					cmd.emit_buf = 1'b1;
					cmd.last     = key_mode_q && sts.flush_done;
					cmd.idx_inc  = 1'b1;
					if (sts.flush_done) begin
						cmd.cnt_clr = 1'b1;
						state_d     = key_mode_q ? S_WR : S_BTN;
					end else begin
						state_d = S_FRD;
					end
				end
			end
			S_BTN: begin
				if (sts.btn_none) begin
					state_d = S_SYN;
				end else if (sts.out_free) begin
					cmd.emit_btn = 1'b1;
				end
			end
			S_SYN: begin
				if (sts.out_free) begin
					cmd.emit_sync = 1'b1;
					cmd.last      = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/kcmb_dp.sv =====
// ----------------------------------------------------------------------------
// kcmb_dp
// Datapath: key state, button evaluation, event buffer and output register
// ----------------------------------------------------------------------------
module kcmb_dp
	import kcmb_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int MAX_MAPS     = MAX_MAPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [2:0]                num_buttons,
	input  entry_t [MAX_MAPS-1:0]     map_entry,
	input  logic [1:0]                in_type,
	input  logic [15:0]               in_code,
	input  logic [1:0]                in_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_type,
	output logic [15:0]               out_code,
	output logic [1:0]                out_value,
	output logic                      out_last
);

	localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int SW = 2 * MAX_MAPS;

	// latched input item
	logic [1:0]  in_type_q;
	logic [15:0] in_code_q;
	logic [1:0]  in_value_q;

	// key and button state
	logic [SW-1:0]       pressed_q;
	logic [MAX_MAPS-1:0] down_q;
	logic [MAX_MAPS-1:0] changed_q;
	logic [MAX_MAPS-1:0] press_q;
	logic [1:0]          flag_q;

	// event buffer
	logic [17:0]   mem [BUFFER_DEPTH];
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic [15:0]   rd_code_s1;
	logic [1:0]    rd_value_s1;

	// output register
	logic        out_valid_q;
	logic        out_type_q;
	logic [15:0] out_code_q;
	logic [1:0]  out_value_q;
	logic        out_last_q;

	logic [2:0]          n_use;
	logic [MAX_MAPS-1:0] in_use;
	logic [SW-1:0]       match;
	logic [MAX_MAPS-1:0] down_new;
	logic [MAX_MAPS-1:0] ovr;
	logic [MAX_MAPS-1:0] changed;
	logic                found;
	logic                btn_found;
	logic [MAX_MAPS-1:0] btn_sel;
	logic [MAX_MAPS-1:0] rw_sel;
	logic                rw_hit;
	logic [15:0]         btn_code;
	logic                btn_value;
	logic [15:0]         rw_code;
	logic                np;
	logic                watched_live;

	// entries in use, saturated
	assign n_use = (num_buttons > 3'(MAX_MAPS)) ? 3'(MAX_MAPS) : num_buttons;

	// slot match for the latched key code
	always_comb begin
		for (int i = 0; i < MAX_MAPS; i++) begin
			in_use[i]        = (3'(i) < n_use);
			match[2*i]       = in_use[i] && (map_entry[i].key == in_code_q);
			match[2*i+1]     = in_use[i] && (map_entry[i].modifier != 16'd0)
				&& (map_entry[i].modifier == in_code_q);
		end
	end

	assign watched_live = (match != '0) && (flag_q != FLAG_RESYNC);
	assign np           = (in_value_q != VAL_RELEASE);

	// button evaluation with modifier hysteresis and override
	always_comb begin
		ovr = '0;
		for (int i = 0; i < MAX_MAPS; i++) begin
			down_new[i] = pressed_q[2*i] && ((map_entry[i].modifier == 16'd0)
				|| down_q[i] || pressed_q[2*i+1]);
			found = 1'b0;
			for (int j = 0; j < MAX_MAPS; j++) begin
				if (in_use[i] && in_use[j] && (map_entry[i].modifier != 16'd0)
					&& (down_new[i] || down_q[i]) && !found
					&& (map_entry[j].modifier == 16'd0)
					&& (map_entry[j].key == map_entry[i].key)) begin
					ovr[j] = 1'b1;
					found  = 1'b1;
				end
			end
		end
		changed = ((down_new & ~ovr) ^ down_q) & in_use;
	end

	// lowest pending button
	always_comb begin
		btn_sel   = '0;
		btn_code  = '0;
		btn_value = 1'b0;
		btn_found = 1'b0;
		for (int i = 0; i < MAX_MAPS; i++) begin
			if (changed_q[i] && !btn_found) begin
				btn_sel[i] = 1'b1;
				btn_code   = map_entry[i].mouse;
				btn_value  = down_q[i];
				btn_found  = 1'b1;
			end
		end
	end

	// rewrite of the first buffered press of a newly pressed button's key
	always_comb begin
		rw_sel  = '0;
		rw_hit  = 1'b0;
		rw_code = rd_code_s1;
		for (int i = 0; i < MAX_MAPS; i++) begin
			if (press_q[i] && !rw_hit && (rd_value_s1 != VAL_RELEASE)
				&& (map_entry[i].key == rd_code_s1)) begin
				rw_sel[i] = 1'b1;
				rw_hit    = 1'b1;
				if (map_entry[i].modifier != 16'd0) begin
					rw_code = map_entry[i].modifier;
				end
			end
		end
	end

	// status
	always_comb begin
		sts.typ_key    = (in_type_q == TYPE_KEY);
		sts.typ_sync   = (in_type_q == TYPE_SYNC);
		sts.drop       = watched_live && (in_value_q == VAL_REPEAT);
		sts.full       = (count_q == CW'(BUFFER_DEPTH));
		sts.cnt_zero   = (count_q == '0);
		sts.flush_done = (CW'(idx_q) == count_q - CW'(1));
		sts.btn_none   = (changed_q == '0);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_type_q  <= in_type;
			in_code_q  <= in_code;
			in_value_q <= in_value;
		end
	end

	// key state, flag and button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
			down_q    <= '0;
			changed_q <= '0;
			press_q   <= '0;
			flag_q    <= FLAG_NONE;
		end else begin
			// a flush on a full buffer rewrites nothing
			if (cmd.key_upd) begin
				press_q <= '0;
			end
			if (cmd.key_upd && watched_live) begin
				if (np != ((pressed_q & match) != '0)) begin
					flag_q <= FLAG_CHANGED;
				end
				pressed_q <= np ? (pressed_q | match) : (pressed_q & ~match);
			end
			if (cmd.sync_upd) begin
				if (in_code_q == SYNC_DROPPED) begin
					flag_q    <= FLAG_RESYNC;
					pressed_q <= '0;
					changed_q <= '0;
					press_q   <= '0;
				end else if ((in_code_q == SYNC_REPORT) && (flag_q != FLAG_NONE)) begin
					flag_q    <= FLAG_NONE;
					down_q    <= down_q ^ changed;
					changed_q <= changed;
					press_q   <= changed & ~down_q;
				end else begin
					changed_q <= '0;
					press_q   <= '0;
				end
			end
			if (cmd.emit_btn) begin
				changed_q <= changed_q & ~btn_sel;
			end
			if (cmd.emit_buf) begin
				press_q <= press_q & ~rw_sel;
			end
		end
	end

	// buffer fill count and flush index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
				idx_q   <= '0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + IW'(1);
				end
				if (cmd.wr) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// buffer memory
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[count_q[IW-1:0]] <= {in_code_q, in_value_q};
		end
		if (cmd.rd) begin
			{rd_code_s1, rd_value_s1} <= mem[idx_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_buf || cmd.emit_btn || cmd.emit_sync) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_buf) begin
			out_type_q  <= 1'b0;
			out_code_q  <= rw_code;
			out_value_q <= rw_hit ? VAL_RELEASE : rd_value_s1;
			out_last_q  <= cmd.last;
		end else if (cmd.emit_btn) begin
			out_type_q  <= 1'b0;
			out_code_q  <= btn_code;
			out_value_q <= {1'b0, btn_value};
			out_last_q  <= 1'b0;
		end else if (cmd.emit_sync) begin
			out_type_q  <= 1'b1;
			out_code_q  <= in_code_q;
			out_value_q <= in_value_q;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_type  = out_type_q;
	assign out_code  = out_code_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/core/kcmb_chk.sv =====
// ----------------------------------------------------------------------------
// kcmb_chk
// Port-level checks of the key chord to mouse button block
// ----------------------------------------------------------------------------
module kcmb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// a stalled output transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	// a sync event always closes its item
	a_sync_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tlast)
		else $error("sync event without tlast");

	// one item at a time: input not ready right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[23:19] == 5'd0))
		else $error("output padding not zero");

endmodule

bind key_chord_to_mouse_button kcmb_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_key_chord_to_mouse_button.sv =====
// ----------------------------------------------------------------------------
// tb_key_chord_to_mouse_button
// Self-checking bench: a queue-fed stream driver, a stream monitor and a
// behavioral predictor of the chord filter, run over several register setups
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_key_chord_to_mouse_button;
	import kcmb_pkg::*;

	localparam logic [1:0] TYPE_OTHER = 2'd2;
	localparam logic [1:0] VAL_PRESS  = 2'd1;
	localparam int         HOLD_LEN   = 400;

	typedef struct packed {
		logic [1:0]  typ;
		logic [15:0] code;
		logic [1:0]  val;
	} key_event_t;

	typedef struct packed {
		logic        typ;
		logic [15:0] code;
		logic [1:0]  val;
		logic        last;
	} out_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // event_type, event_code, event_value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // out_type, out_code, out_value
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	key_chord_to_mouse_button DUT (.*);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirrored registers and filter state
	logic [2:0]  btn_count_cfg = NUM_BUTTONS_RST;
	entry_t      chord_map [NUM_ENTRY_REGS];
	logic [11:0] keys_held;
	logic [5:0]  buttons_down;
	logic [1:0]  pending;
	logic [15:0] held_code [BUFFER_DEPTH_DEF];
	logic [1:0]  held_val [BUFFER_DEPTH_DEF];
	int          held_cnt;

	key_event_t  send_q [$];
	out_event_t  expected_q [$];
	int          fail_cnt = 0;
	int          rx_count = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          hold_cnt = 0;
	bit          hold_done = 1'b0;
	bit          calm = 1'b0;
	int          cyc = 0;

	initial begin
		for (int i = 0; i < NUM_ENTRY_REGS; i++)
			chord_map[i] = MAP_RST[i];
		keys_held = '0;
		buttons_down = '0;
		pending = FLAG_NONE;
		held_cnt = 0;
	end

	function automatic int maps_used();
		return (btn_count_cfg > MAX_MAPS_DEF) ? MAX_MAPS_DEF : int'(btn_count_cfg);
	endfunction

	function automatic logic [11:0] slots_of(logic [15:0] code);
		logic [11:0] m;
		m = '0;
		for (int i = 0; i < maps_used(); i++) begin
			if (chord_map[i].key == code)
				m[2*i] = 1'b1;
			if (chord_map[i].modifier != 0 && chord_map[i].modifier == code)
				m[2*i+1] = 1'b1;
		end
		return m;
	endfunction

	// which buttons flip on a report
	function automatic logic [5:0] button_flips();
		logic [5:0] dn;
		logic [5:0] ovr;
		logic [5:0] mask;
		bit was;
		bit d;
		dn = '0;
		ovr = '0;
		for (int i = 0; i < maps_used(); i++) begin
			was = buttons_down[i];
			d = keys_held[2*i] &&
				(chord_map[i].modifier == 0 || was || keys_held[2*i+1]);
			dn[i] = d;
			if (chord_map[i].modifier != 0 && (d || was)) begin
				for (int j = 0; j < maps_used(); j++) begin
					if (chord_map[j].modifier == 0 && chord_map[j].key == chord_map[i].key) begin
						ovr[j] = 1'b1;
						break;
					end
				end
			end
		end
		mask = 6'((7'd1 << maps_used()) - 1);
		return ((dn & ~ovr) ^ buttons_down) & mask;
	endfunction

	function automatic void release_held();
		for (int i = 0; i < held_cnt; i++)
			expected_q.push_back('{1'b0, held_code[i], held_val[i], 1'b0});
		held_cnt = 0;
	endfunction

	// expected output of one accepted input event
	function automatic void predict_event(key_event_t e);
		logic [11:0] m;
		logic [5:0]  flips;
		logic [15:0] bcode [6];
		logic [1:0]  bval [6];
		int nb;
		int base;
		bit np;
		bit going_down;
		base = expected_q.size();
		nb = 0;
		flips = '0;
		if (e.typ == TYPE_KEY) begin
			m = slots_of(e.code);
			if (m != 0 && pending != FLAG_RESYNC) begin
				if (e.val == VAL_REPEAT)
					return;
				np = (e.val != VAL_RELEASE);
				if (np != ((keys_held & m) != 0))
					pending = FLAG_CHANGED;
				keys_held = np ? (keys_held | m) : (keys_held & ~m);
			end
			if (held_cnt >= BUFFER_DEPTH_DEF)
				release_held();
			held_code[held_cnt] = e.code;
			held_val[held_cnt] = e.val;
			held_cnt++;
		end else if (e.typ == TYPE_SYNC) begin
			if (e.code == SYNC_DROPPED) begin
				pending = FLAG_RESYNC;
				keys_held = '0;
			end else if (e.code == SYNC_REPORT && pending != FLAG_NONE) begin
				flips = button_flips();
				pending = FLAG_NONE;
			end
			for (int i = 0; i < maps_used(); i++) begin
				if (flips[i]) begin
					going_down = !buttons_down[i];
					buttons_down[i] = !buttons_down[i];
					bcode[nb] = chord_map[i].mouse;
					bval[nb] = going_down ? VAL_PRESS : VAL_RELEASE;
					nb++;
					// hide the key press that made the chord
					if (going_down) begin
						for (int k = 0; k < held_cnt; k++) begin
							if (held_code[k] == chord_map[i].key && held_val[k] != VAL_RELEASE) begin
								held_val[k] = VAL_RELEASE;
								if (chord_map[i].modifier != 0)
									held_code[k] = chord_map[i].modifier;
								break;
							end
						end
					end
				end
			end
			release_held();
			for (int i = 0; i < nb; i++)
				expected_q.push_back('{1'b0, bcode[i], bval[i], 1'b0});
			expected_q.push_back('{1'b1, e.code, e.val, 1'b0});
		end else begin
			return;
		end
		if (expected_q.size() > base)
			expected_q[expected_q.size()-1].last = 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_event(key_event_t'{s_axis_tdata[1:0], s_axis_tdata[17:2],
					s_axis_tdata[19:18]});
				tx_gap = pick_gap();
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (send_q.size() > 0) begin
					key_event_t e;
					e = send_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0, e.val, e.code, e.typ};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver readiness
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_event_t x;
				rx_count++;
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer: code %h", m_axis_tdata[16:1]);
					fail_cnt++;
				end else begin
					x = expected_q.pop_front();
					if (m_axis_tdata[0] !== x.typ) begin
						$error("out_type: expected %h, got %h", x.typ, m_axis_tdata[0]);
						fail_cnt++;
					end
					if (m_axis_tdata[16:1] !== x.code) begin
						$error("out_code: expected %h, got %h", x.code, m_axis_tdata[16:1]);
						fail_cnt++;
					end
					if (m_axis_tdata[18:17] !== x.val) begin
						$error("out_value: expected %h, got %h", x.val, m_axis_tdata[18:17]);
						fail_cnt++;
					end
					if (m_axis_tlast !== x.last) begin
						$error("out_last: expected %h, got %h", x.last, m_axis_tlast);
						fail_cnt++;
					end
				end
				rx_gap = pick_gap();
			end
			if (hold_cnt > 0) begin
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// long receiver hold-off and calm stretches
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 700 == 0)
			calm <= ($urandom_range(0, 3) == 0);
		if (hold_cnt > 0)
			hold_cnt <= hold_cnt - 1;
		else if (!hold_done && rx_count >= 150) begin
			hold_cnt <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_NUM_BUTTONS)
			btn_count_cfg = value[2:0];
		else
			chord_map[idx - REG_MAP_FIRST] = value[47:0];
	endtask

	task automatic wait_idle();
		wait (send_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic void push_ev(logic [1:0] t, logic [15:0] c, logic [1:0] v);
		send_q.push_back('{t, c, v});
	endfunction

	// a key or modifier code from the mapping table
	function automatic logic [15:0] watched_code();
		int i;
		i = $urandom_range(0, MAX_MAPS_DEF - 1);
		if ($urandom_range(0, 2) == 0 && chord_map[i].modifier != 0)
			return chord_map[i].modifier;
		return chord_map[i].key;
	endfunction

	function automatic void random_events(int n);
		int r;
		int done;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			done++;
			if (r < 58)
				push_ev(TYPE_KEY, watched_code(),
					($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1)));
			else if (r < 70)
				push_ev(TYPE_KEY, 16'($urandom), 2'($urandom));
			else if (r < 88)
				push_ev(TYPE_SYNC, SYNC_REPORT, 2'd0);
			else if (r < 92)
				push_ev(TYPE_SYNC, SYNC_DROPPED, 2'd0);
			else if (r < 96)
				push_ev(TYPE_SYNC, 16'($urandom), 2'($urandom));
			else begin
				push_ev(2'($urandom_range(2, 3)), 16'($urandom), 2'($urandom));
				done--;
			end
		end
	endfunction

	function automatic logic [63:0] small_entry();
		logic [15:0] k;
		logic [15:0] md;
		k = 16'($urandom_range(1, 10));
		md = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
		return {16'd0, 16'($urandom), k, md};
	endfunction

	// stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset mapping
		push_ev(TYPE_KEY, chord_map[0].key, VAL_PRESS);
		push_ev(TYPE_KEY, chord_map[0].key, VAL_REPEAT);
		push_ev(TYPE_SYNC, SYNC_REPORT, 2'd0);
		push_ev(TYPE_KEY, chord_map[0].key, VAL_RELEASE);
		push_ev(TYPE_KEY, 16'hFFFF, 2'd3);
		push_ev(TYPE_OTHER, 16'h1234, 2'd1);
		push_ev(2'd3, 16'hFFFF, 2'd3);
		push_ev(TYPE_SYNC, SYNC_REPORT, 2'd0);
		push_ev(TYPE_KEY, chord_map[1].key, 2'd3);
		push_ev(TYPE_SYNC, SYNC_DROPPED, 2'd0);
		push_ev(TYPE_KEY, chord_map[1].key, VAL_REPEAT);
		push_ev(TYPE_SYNC, SYNC_REPORT, 2'd0);
		// overfill the buffer, then an unknown sync code
		for (int i = 0; i < 18; i++)
			push_ev(TYPE_KEY, 16'(i), VAL_PRESS);
		push_ev(TYPE_SYNC, 16'hFFFF, 2'd3);
		wait_idle();

		// modifier chord overriding a plain mapping, all slots used
		reg_write(REG_NUM_BUTTONS, 64'd6);
		reg_write(3'd1, {16'd0, 16'h0110, 16'd30, 16'd0});
		reg_write(3'd2, {16'd0, 16'h0111, 16'd30, 16'd29});
		reg_write(3'd3, {16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		reg_write(3'd4, {16'd0, 16'h0112, 16'd31, 16'd0});
		reg_write(3'd5, {16'd0, 16'h0113, 16'd0, 16'd0});
		reg_write(3'd6, {16'd0, 16'h0114, 16'd31, 16'd30});
		push_ev(TYPE_KEY, 16'd29, VAL_PRESS);
		push_ev(TYPE_KEY, 16'd30, VAL_PRESS);
		push_ev(TYPE_SYNC, SYNC_REPORT, 2'd0);
		push_ev(TYPE_KEY, 16'd29, VAL_RELEASE);
		push_ev(TYPE_SYNC, SYNC_REPORT, 2'd0);
		push_ev(TYPE_KEY, 16'd30, VAL_RELEASE);
		push_ev(TYPE_SYNC, SYNC_REPORT, 2'd0);
		random_events(60);
		wait_idle();

		// count above the slot limit saturates
		reg_write(REG_NUM_BUTTONS, 64'd7);
		for (int i = 0; i < NUM_ENTRY_REGS; i++)
			reg_write(3'(i) + REG_MAP_FIRST, small_entry());
		random_events(60);
		wait_idle();

		// no mappings: everything passes
		reg_write(REG_NUM_BUTTONS, 64'd0);
		random_events(30);
		wait_idle();

		// full-range entries
		reg_write(REG_NUM_BUTTONS, 64'($urandom_range(1, 6)));
		for (int i = 0; i < NUM_ENTRY_REGS; i++)
			reg_write(3'(i) + REG_MAP_FIRST, {$urandom, $urandom});
		random_events(40);
		wait_idle();

		reg_write(REG_NUM_BUTTONS, 64'($urandom_range(1, 6)));
		for (int i = 0; i < NUM_ENTRY_REGS; i++)
			reg_write(3'(i) + REG_MAP_FIRST, small_entry());
		random_events(60);

		wait (send_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0);
		repeat (60) @(posedge clk);
		if (fail_cnt == 0)
			$display("PASS key_chord_to_mouse_button");
		else
			$display("FAIL key_chord_to_mouse_button");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("FAIL key_chord_to_mouse_button");
		$finish;
	end

endmodule
